// ===== hw/rtl/dpsm_pkg.sv =====
// Shared types and constants for the drive power state machine.
// No dependencies; imported by dpsm_step, drive_power_state_machine and tb.
`timescale 1ns / 1ps
`default_nettype none

package dpsm_pkg;

    typedef enum logic [2:0] {
        ST_NOT_READY   = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_READY       = 3'd2,
        ST_SWITCHED_ON = 3'd3,
        ST_ENABLED     = 3'd4,
        ST_QUICK_STOP  = 3'd5,
        ST_FAULT_REACT = 3'd6,
        ST_FAULT       = 3'd7
    } drive_state_t;

    typedef enum logic [3:0] {
        TR_NONE            = 4'd0,
        TR_NOTREADY_DIS    = 4'd1,
        TR_DIS_READY       = 4'd2,
        TR_READY_DIS       = 4'd3,
        TR_READY_SWON      = 4'd4,
        TR_READY_EN        = 4'd5,
        TR_SWON_READY      = 4'd6,
        TR_SWON_EN         = 4'd7,
        TR_SWON_DIS        = 4'd8,
        TR_EN_SWON         = 4'd9,
        TR_EN_READY        = 4'd10,
        TR_EN_DIS          = 4'd11,
        TR_EN_QSTOP        = 4'd12,
        TR_QSTOP_DIS       = 4'd13,
        TR_FREACT_FAULT    = 4'd14,
        TR_FAULT_DIS       = 4'd15
    } trans_code_t;

    // flags packed {config, enable, power, brake}
    typedef logic [3:0] power_flags_t;

    localparam power_flags_t FLAGS_IDLE   = 4'h9;
    localparam power_flags_t FLAGS_SWON   = 4'hB;
    localparam power_flags_t FLAGS_ACTIVE = 4'h6;
    localparam power_flags_t FLAGS_FAULT  = 4'h8;
    localparam power_flags_t FLAGS_RESET  = 4'h0;

    localparam logic [15:0] LINK_OPERATIONAL = 16'd8;

    localparam logic [15:0] SW_NOT_READY   = 16'h0000;
    localparam logic [15:0] SW_DISABLED    = 16'h0040;
    localparam logic [15:0] SW_READY       = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
    localparam logic [15:0] SW_ENABLED     = 16'h0027;
    localparam logic [15:0] SW_QUICK_STOP  = 16'h0007;
    localparam logic [15:0] SW_FAULT_REACT = 16'h000F;
    localparam logic [15:0] SW_FAULT       = 16'h0008;

    typedef struct packed {
        power_flags_t prev_flags;
        power_flags_t flags;
        trans_code_t  code;
        logic [15:0]  status_word;
    } step_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drive_power_state_machine.sv =====
// An accepted input beat goes to the input register, then through dpsm_step into the
// result register that drives m_*. One beat per cycle unless m_tready stalls the result
// register. The drive state and flags update as a beat leaves the input register.
// Reset (aresetn low, synchronous): both stages empty, state not-ready, flags zero.
`timescale 1ns / 1ps
`default_nettype none

module drive_power_state_machine import dpsm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] control_word, [31:16] link_status
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [15:0] status_word, [19:16] transition_code,
                                        // [20] cfg_permitted, [21] axis_enabled,
                                        // [22] power_applied, [23] brake_engaged,
                                        // [27:24] previous_flags, [31:28] zero
);

    logic         in_valid_reg, in_valid_next;
    logic [15:0]  cw_reg, cw_next;
    logic [15:0]  link_reg, link_next;
    logic         out_valid_reg, out_valid_next;
    step_result_t out_reg, out_next;
    drive_state_t state_reg, state_next;
    power_flags_t flags_reg, flags_next;

    drive_state_t step_state;
    power_flags_t step_flags;
    step_result_t step_result;
    logic         advance;
    logic         fire;

    dpsm_step u_step (
        .state_i      (state_reg),
        .flags_i      (flags_reg),
        .control_word (cw_reg),
        .link_status  (link_reg),
        .state_o      (step_state),
        .flags_o      (step_flags),
        .result_o     (step_result)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        cw_next        = cw_reg;
        link_next      = link_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        state_next     = state_reg;
        flags_next     = flags_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            cw_next       = s_tdata[15:0];
            link_next     = s_tdata[31:16];
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_next       = step_result;
        end
        if (fire) begin
            state_next = step_state;
            flags_next = step_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_NOT_READY;
            flags_reg     <= FLAGS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            flags_reg     <= flags_next;
        end
        cw_reg   <= cw_next;
        link_reg <= link_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0,
                       out_reg.prev_flags,
                       out_reg.flags[0], out_reg.flags[1],
                       out_reg.flags[2], out_reg.flags[3],
                       out_reg.code,
                       out_reg.status_word};

    // state only moves when a beat passes to the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("drive state changed without a beat");

    // a beat moving on always shows up as a result
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("beat lost between stages");

    // a zero code exactly when the state does not change
    a_code_match: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> ((step_result.code == TR_NONE) == (step_state == state_reg)))
        else $error("transition code inconsistent with state change");

    // motion states always carry the active flag set
    a_active_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENABLED || state_reg == ST_QUICK_STOP)
            |-> (flags_reg == FLAGS_ACTIVE))
        else $error("flags wrong in enabled or quick stop");

endmodule

`default_nettype wire

// ===== hw/rtl/dpsm_step.sv =====
// Transition logic: decodes the controlword and link status, picks the next
// drive state, transition code, flags and statusword. Uses dpsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpsm_step import dpsm_pkg::*; (
    input  drive_state_t state_i,
    input  power_flags_t flags_i,
    input  logic [15:0]  control_word,
    input  logic [15:0]  link_status,
    output drive_state_t state_o,
    output power_flags_t flags_o,
    output step_result_t result_o
);

    logic        link_op;
    logic        cmd_shutdown;
    logic        cmd_sw_on;
    logic        cmd_sw_on_en;
    logic        cmd_dis_volt;
    logic        cmd_qstop;
    logic        cmd_dis_op;
    logic        cmd_en_op;
    logic        cmd_f_reset;
    trans_code_t code;

    assign link_op      = (link_status == LINK_OPERATIONAL);
    assign cmd_shutdown = ((control_word & 16'h0087) == 16'h0006);
    assign cmd_sw_on    = ((control_word & 16'h0087) == 16'h0007);
    assign cmd_sw_on_en = ((control_word & 16'h008F) == 16'h000F);
    assign cmd_dis_volt = ((control_word & 16'h0082) == 16'h0000);
    assign cmd_qstop    = ((control_word & 16'h0086) == 16'h0002);
    assign cmd_dis_op   = ((control_word & 16'h008F) == 16'h0007);
    assign cmd_en_op    = ((control_word & 16'h008F) == 16'h000F);
    assign cmd_f_reset  = ((control_word & 16'h0080) == 16'h0080);

    // next state; within a state the first matching command wins
    always_comb begin
        state_o = state_i;
        code    = TR_NONE;
        unique case (state_i)
            ST_NOT_READY: begin
                if (link_op) begin
                    state_o = ST_DISABLED;
                    code    = TR_NOTREADY_DIS;
                end
            end
            ST_DISABLED: begin
                if (cmd_shutdown || link_op) begin
                    state_o = ST_READY;
                    code    = TR_DIS_READY;
                end
            end
            ST_READY: begin
                priority if (cmd_dis_volt) begin
                    state_o = ST_DISABLED;
                    code    = TR_READY_DIS;
                end else if (cmd_sw_on && cmd_sw_on_en) begin
                    state_o = ST_ENABLED;
                    code    = TR_READY_EN;
                end else if (cmd_sw_on) begin
                    state_o = ST_SWITCHED_ON;
                    code    = TR_READY_SWON;
                end
            end
            ST_SWITCHED_ON: begin
                priority if (cmd_shutdown) begin
                    state_o = ST_READY;
                    code    = TR_SWON_READY;
                end else if (cmd_en_op) begin
                    state_o = ST_ENABLED;
                    code    = TR_SWON_EN;
                end else if (cmd_dis_volt) begin
                    state_o = ST_DISABLED;
                    code    = TR_SWON_DIS;
                end
            end
            ST_ENABLED: begin
                // link loss drops to switch-on-disabled unless disable operation or shutdown is commanded
                priority if (cmd_dis_op) begin
                    state_o = ST_SWITCHED_ON;
                    code    = TR_EN_SWON;
                end else if (cmd_shutdown) begin
                    state_o = ST_READY;
                    code    = TR_EN_READY;
                end else if (cmd_dis_volt || !link_op) begin
                    state_o = ST_DISABLED;
                    code    = TR_EN_DIS;
                end else if (cmd_qstop) begin
                    state_o = ST_QUICK_STOP;
                    code    = TR_EN_QSTOP;
                end
            end
            ST_QUICK_STOP: begin
                if (cmd_dis_volt) begin
                    state_o = ST_DISABLED;
                    code    = TR_QSTOP_DIS;
                end
            end
            ST_FAULT_REACT: begin
                state_o = ST_FAULT;
                code    = TR_FREACT_FAULT;
            end
            ST_FAULT: begin
                if (cmd_f_reset) begin
                    state_o = ST_DISABLED;
                    code    = TR_FAULT_DIS;
                end
            end
            default: begin
                state_o = state_i;
                code    = TR_NONE;
            end
        endcase
    end

    // outputs of the new state
    always_comb begin
        flags_o              = flags_i;
        result_o.status_word = SW_NOT_READY;
        unique case (state_o)
            ST_NOT_READY: begin
                result_o.status_word = SW_NOT_READY;
            end
            ST_DISABLED: begin
                flags_o              = FLAGS_IDLE;
                result_o.status_word = SW_DISABLED;
            end
            ST_READY: begin
                flags_o              = FLAGS_IDLE;
                result_o.status_word = SW_READY;
            end
            ST_SWITCHED_ON: begin
                flags_o              = FLAGS_SWON;
                result_o.status_word = SW_SWITCHED_ON;
            end
            ST_ENABLED: begin
                flags_o              = FLAGS_ACTIVE;
                result_o.status_word = SW_ENABLED;
            end
            ST_QUICK_STOP: begin
                flags_o              = FLAGS_ACTIVE;
                result_o.status_word = SW_QUICK_STOP;
            end
            ST_FAULT_REACT: begin
                result_o.status_word = SW_FAULT_REACT;
            end
            ST_FAULT: begin
                flags_o              = FLAGS_FAULT;
                result_o.status_word = SW_FAULT;
            end
            default: begin
                flags_o              = flags_i;
                result_o.status_word = SW_NOT_READY;
            end
        endcase
        result_o.code       = code;
        result_o.flags      = flags_o;
        result_o.prev_flags = flags_i;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for drive_power_state_machine: directed and random controlword beats.
// A scoreboard class tracks the CiA 402 drive state and predicts every result beat.
// Depends on dpsm_pkg and drive_power_state_machine.
`timescale 1ns / 1ps

module tb;
    import dpsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BEATS   = 570;

    // Tracks drive state and flags; holds the predicted result beats in order.
    class power_state_tracker;
        drive_state_t state;
        power_flags_t flags;
        step_result_t expected_q[$];
        int           mismatches;
        int           checked;
        logic [15:0]  codes_seen;

        function new();
            state      = ST_NOT_READY;
            flags      = FLAGS_RESET;
            mismatches = 0;
            checked    = 0;
            codes_seen = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(logic [15:0] cw, logic [15:0] link);
            logic         link_up, shutdown, swon_cmd, enable_op, disable_volt;
            logic         qstop_cmd, disable_op, clear_cmd;
            drive_state_t new_state;
            trans_code_t  code;
            step_result_t r;
            link_up      = (link == LINK_OPERATIONAL);
            shutdown     = (cw & 16'h0087) == 16'h0006;
            swon_cmd     = (cw & 16'h0087) == 16'h0007;
            enable_op    = (cw & 16'h008F) == 16'h000F;
            disable_volt = (cw & 16'h0082) == 16'h0000;
            qstop_cmd    = (cw & 16'h0086) == 16'h0002;
            disable_op   = (cw & 16'h008F) == 16'h0007;
            clear_cmd    = (cw & 16'h0080) == 16'h0080;
            new_state    = state;
            code         = TR_NONE;
            case (state)
                ST_NOT_READY: begin
                    if (link_up) begin new_state = ST_DISABLED; code = TR_NOTREADY_DIS; end
                end
                ST_DISABLED: begin
                    if (shutdown || link_up) begin new_state = ST_READY; code = TR_DIS_READY; end
                end
                ST_READY: begin
                    if (disable_volt) begin
                        new_state = ST_DISABLED; code = TR_READY_DIS;
                    end else if (swon_cmd) begin
                        // bit 3 decides between plain switch-on and switch-on plus enable
                        if (enable_op) begin new_state = ST_ENABLED; code = TR_READY_EN; end
                        else begin new_state = ST_SWITCHED_ON; code = TR_READY_SWON; end
                    end
                end
                ST_SWITCHED_ON: begin
                    if (shutdown) begin new_state = ST_READY; code = TR_SWON_READY; end
                    else if (enable_op) begin new_state = ST_ENABLED; code = TR_SWON_EN; end
                    else if (disable_volt) begin new_state = ST_DISABLED; code = TR_SWON_DIS; end
                end
                ST_ENABLED: begin
                    if (disable_op) begin new_state = ST_SWITCHED_ON; code = TR_EN_SWON; end
                    else if (shutdown) begin new_state = ST_READY; code = TR_EN_READY; end
                    else if (disable_volt || !link_up) begin
                        new_state = ST_DISABLED; code = TR_EN_DIS;
                    end else if (qstop_cmd) begin
                        new_state = ST_QUICK_STOP; code = TR_EN_QSTOP;
                    end
                end
                ST_QUICK_STOP: begin
                    // enable operation does not leave quick stop
                    if (disable_volt) begin new_state = ST_DISABLED; code = TR_QSTOP_DIS; end
                end
                ST_FAULT_REACT: begin
                    new_state = ST_FAULT; code = TR_FREACT_FAULT;
                end
                default: begin
                    if (clear_cmd) begin new_state = ST_DISABLED; code = TR_FAULT_DIS; end
                end
            endcase

            r.prev_flags = flags;
            case (new_state)
                ST_DISABLED, ST_READY:     flags = FLAGS_IDLE;
                ST_SWITCHED_ON:            flags = FLAGS_SWON;
                ST_ENABLED, ST_QUICK_STOP: flags = FLAGS_ACTIVE;
                ST_FAULT:                  flags = FLAGS_FAULT;
                default:                   flags = flags;
            endcase
            case (new_state)
                ST_NOT_READY:   r.status_word = SW_NOT_READY;
                ST_DISABLED:    r.status_word = SW_DISABLED;
                ST_READY:       r.status_word = SW_READY;
                ST_SWITCHED_ON: r.status_word = SW_SWITCHED_ON;
                ST_ENABLED:     r.status_word = SW_ENABLED;
                ST_QUICK_STOP:  r.status_word = SW_QUICK_STOP;
                ST_FAULT_REACT: r.status_word = SW_FAULT_REACT;
                default:        r.status_word = SW_FAULT;
            endcase
            r.flags = flags;
            r.code  = code;
            state   = new_state;
            codes_seen[code] = 1'b1;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_status(logic [31:0] beat);
            step_result_t e;
            if (expected_q.size() == 0) begin
                $error("result beat 0x%08h arrived with nothing expected", beat);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare_field("status_word", e.status_word, beat[15:0]);
            compare_field("transition_code", e.code, beat[19:16]);
            compare_field("cfg_permitted", e.flags[3], beat[20]);
            compare_field("axis_enabled", e.flags[2], beat[21]);
            compare_field("power_applied", e.flags[1], beat[22]);
            compare_field("brake_engaged", e.flags[0], beat[23]);
            compare_field("previous_flags", e.prev_flags, beat[27:24]);
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] control_word, [31:16] link_status
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [15:0] status_word, [19:16] transition_code,
                                  // [20] cfg_permitted, [21] axis_enabled,
                                  // [22] power_applied, [23] brake_engaged,
                                  // [27:24] previous_flags, [31:28] zero

    int send_idle   = 15;
    int recv_idle   = 74;
    int idle_cycles = 0;
    int beats_in    = 0;

    power_state_tracker tracker = new();

    // controlword / link pairs walking every reachable transition
    logic [15:0] dir_cw[24] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'h0006, 16'h0000, 16'h0000,
        16'h0007, 16'h0006, 16'h000F, 16'h0007, 16'h000F, 16'h0006,
        16'h000F, 16'h000F, 16'h0006, 16'h000F, 16'h000B, 16'h000F,
        16'hFFFF, 16'h0000, 16'h0006, 16'h0007, 16'h0000, 16'h0087
    };
    logic [15:0] dir_link[24] = '{
        16'h0000, 16'hFFFF, 16'h0008, 16'h0000, 16'h0000, 16'h0008,
        16'h0008, 16'h0008, 16'h0008, 16'h0008, 16'h0008, 16'h0008,
        16'h0008, 16'h0000, 16'h0000, 16'h0008, 16'h0008, 16'h0008,
        16'h0008, 16'h0008, 16'h0009, 16'hFFF8, 16'h0007, 16'h0008
    };

    drive_power_state_machine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            tracker.note_command(s_tdata[15:0], s_tdata[31:16]);
            beats_in++;
        end
        if (aresetn && m_tvalid && m_tready) tracker.check_status(m_tdata);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("drive_power_state_machine regression: fail");
        $finish;
    end

    task automatic send_beat(logic [15:0] cw, logic [15:0] link);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {link, cw};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off the sender until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_command();
        logic [15:0] raw;
        logic [15:0] mask;
        logic [15:0] value;
        raw = 16'($urandom);
        case ($urandom_range(9))
            0: begin mask = 16'h0087; value = 16'h0006; end   // shutdown
            1: begin mask = 16'h0087; value = 16'h0007; end   // switch on
            2, 3: begin mask = 16'h008F; value = 16'h000F; end // enable operation
            4: begin mask = 16'h0082; value = 16'h0000; end   // disable voltage
            5: begin mask = 16'h0086; value = 16'h0002; end   // quick stop
            6: begin mask = 16'h0080; value = 16'h0080; end   // clear fault
            7: begin mask = 16'h008F; value = 16'h0007; end   // disable operation
            default: begin mask = 16'h0000; value = 16'h0000; end
        endcase
        return (raw & ~mask) | value;
    endfunction

    function automatic logic [15:0] random_link();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85) return LINK_OPERATIONAL;
        else if (pick < 92) return 16'($urandom_range(15));
        else return 16'($urandom);
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_beat(random_command(), random_link());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 24; i++) send_beat(dir_cw[i], dir_link[i]);
        drain();
        run_random(RANDOM_BEATS);
        drain();

        send_idle = 74;
        recv_idle = 15;
        run_random(RANDOM_BEATS);
        drain();

        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_BEATS);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d command beats sent, %0d result beats checked, under three stall mixes",
                 beats_in, tracker.checked);
        $display("transition codes seen (one bit per code): %b", tracker.codes_seen);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("drive_power_state_machine regression: pass");
        end else begin
            $display("drive_power_state_machine regression: fail");
        end
        $finish;
    end

endmodule
